// ===== hdl/pdither_pkg.sv =====
// ----------------------------------------------------------------------------
// pdither_pkg
// Shared types, constants and the Bayer offset table of the palette ditherer.
// ----------------------------------------------------------------------------
package pdither_pkg;

   // default sizes
   localparam int DEF_MAX_WIDTH     = 1024;
   localparam int DEF_PALETTE_DEPTH = 16;

   // field widths
   localparam int ERR_W     = 13;  // one channel of stored error, sixteenths
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;
   localparam int SIZE_W    = 16;  // width of size comparisons

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DITHER_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PALETTE_SIZE = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic pal_wr;       // write palette entry from request
      logic load;         // latch pixel request
      logic clear_wr;     // clear one error line entry
      logic line_rd_col;  // read error line at current column
      logic adjust;       // form dithered color, start search
      logic search_issue; // issue one palette entry to the search
      logic err_calc;     // form error, read error line at column - 1
      logic wr_left;      // add 3e into column - 1
      logic wr_cur;       // write diag + 5e into column
      logic emit;         // load result register, advance position
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_done;
      logic search_last;
      logic fs_mode;
      logic rsp_busy;
   } dp_status_type;

   // (k-8)*31/16 truncated, indexed by {row[1:0], col[1:0]}
   function automatic logic signed [5:0] bayer_offset(input logic [3:0] pos);
      logic signed [5:0] off;
      case (pos)
         4'd0:    off = -6'sd3;
         4'd1:    off = 6'sd11;
         4'd2:    off = 6'sd0;
         4'd3:    off = 6'sd15;
         4'd4:    off = 6'sd3;
         4'd5:    off = -6'sd11;
         4'd6:    off = 6'sd7;
         4'd7:    off = -6'sd7;
         4'd8:    off = -6'sd1;
         4'd9:    off = 6'sd13;
         4'd10:   off = -6'sd5;
         4'd11:   off = 6'sd9;
         4'd12:   off = 6'sd5;
         4'd13:   off = -6'sd9;
         4'd14:   off = 6'sd1;
         4'd15:   off = -6'sd13;
         default: off = 6'sd0;
      endcase
      return off;
   endfunction

endpackage

// ===== hdl/pdither_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdither_ctrl
// Sequencer: error line clear, request intake, palette search, error update.
// ----------------------------------------------------------------------------
module pdither_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_cmd,
   output logic                       req_ready,
   input  pdither_pkg::dp_status_type status,
   output pdither_pkg::dp_cmd_type    cmd
);
   import pdither_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FETCH, S_ADJUST, S_SEARCH, S_DRAIN,
      S_ERR, S_WLEFT, S_WCUR, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.pal_wr = accept && req_cmd;
            cmd.load   = accept && !req_cmd;
            if (accept && !req_cmd) state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.line_rd_col = 1'b1;
            state_in        = S_ADJUST;
         end
         S_ADJUST: begin
            cmd.adjust = 1'b1;
            state_in   = S_SEARCH;
         end
         S_SEARCH: begin
            cmd.search_issue = 1'b1;
            if (status.search_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = status.fs_mode ? S_ERR : S_FINISH;
         end
         S_ERR: begin
            cmd.err_calc = 1'b1;
            state_in     = S_WLEFT;
         end
         S_WLEFT: begin
            cmd.wr_left = 1'b1;
            state_in    = S_WCUR;
         end
         S_WCUR: begin
            cmd.wr_cur = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            cmd.emit = !status.rsp_busy;
            if (!status.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // a pixel request always starts the line fetch
   a_pixel_fetch: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_cmd) |=> (state_ff == S_FETCH))
      else $error("pixel request did not start fetch");

   // a result is only loaded when the output register is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.rsp_busy)
      else $error("result loaded over pending result");

endmodule

// ===== hdl/pdither_dp.sv =====
// ----------------------------------------------------------------------------
// pdither_dp
// Datapath: registers, palette, error line memory, search and error math.
// ----------------------------------------------------------------------------
module pdither_dp #(
   parameter int MAX_WIDTH     = pdither_pkg::DEF_MAX_WIDTH,
   parameter int PALETTE_DEPTH = pdither_pkg::DEF_PALETTE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pdither_pkg::dp_cmd_type             cmd,
   output pdither_pkg::dp_status_type          status,
   input  logic                                csr_wr_en,
   input  logic [pdither_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pdither_pkg::CSR_W-1:0]       csr_wdata,
   input  logic [7:0]                          req_red,
   input  logic [7:0]                          req_green,
   input  logic [7:0]                          req_blue,
   input  logic [7:0]                          req_alpha,
   input  logic [3:0]                          req_entry_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_out_red,
   output logic [7:0]                          rsp_out_green,
   output logic [7:0]                          rsp_out_blue,
   output logic [7:0]                          rsp_out_alpha,
   output logic [3:0]                          rsp_chosen_index,
   output logic                                rsp_frame_end
);
   import pdither_pkg::*;

   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int AW  = $clog2(PALETTE_DEPTH);
   localparam int LW  = 3 * ERR_W;

   // configuration
   logic        mode_ff;
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [4:0]  psize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b1;
         width_ff  <= 11'd640;
         height_ff <= 16'd480;
         psize_ff  <= 5'd16;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DITHER_MODE:  mode_ff   <= csr_wdata[0];
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[10:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata[15:0];
            REG_PALETTE_SIZE: psize_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // effective sizes
   logic [SIZE_W-1:0] w_eff, n_eff, h_eff;
   always_comb begin
      if (width_ff == '0)
         w_eff = SIZE_W'(1);
      else if (SIZE_W'(width_ff) > SIZE_W'(MAX_WIDTH))
         w_eff = SIZE_W'(MAX_WIDTH);
      else
         w_eff = SIZE_W'(width_ff);
      if (psize_ff == '0)
         n_eff = SIZE_W'(1);
      else if (SIZE_W'(psize_ff) > SIZE_W'(PALETTE_DEPTH))
         n_eff = SIZE_W'(PALETTE_DEPTH);
      else
         n_eff = SIZE_W'(psize_ff);
      h_eff = (height_ff == '0) ? SIZE_W'(1) : height_ff;
   end

   // frame position
   logic [CLW-1:0] col_ff;
   logic [15:0]    row_ff;
   logic           last_col, last_row;
   assign last_col = (SIZE_W'(col_ff) + SIZE_W'(1)) >= w_eff;
   assign last_row = ({1'b0, row_ff} + 17'd1) >= {1'b0, h_eff};

   // palette store
   logic [31:0] pal_ff [PALETTE_DEPTH];
   always_ff @(posedge clock) begin
      if (cmd.pal_wr && (SIZE_W'(req_entry_index) < SIZE_W'(PALETTE_DEPTH))) begin
         pal_ff[AW'(req_entry_index)] <= {req_alpha, req_blue, req_green, req_red};
      end
   end

   // pixel latch
   logic [7:0] pix_ff [3];
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff[0] <= req_red;
         pix_ff[1] <= req_green;
         pix_ff[2] <= req_blue;
      end
   end

   // error line memory, one write and one registered read per cycle
   logic [LW-1:0]  line_mem [MAX_WIDTH];
   logic [LW-1:0]  rdata_ff;
   logic [CLW-1:0] rd_addr, wr_addr, clr_ff;
   logic [LW-1:0]  wr_data;
   logic           wr_en;
   logic [CLW-1:0] col_m1;

   assign col_m1  = col_ff - CLW'(1);
   assign rd_addr = cmd.err_calc ? col_m1 : col_ff;

   always_ff @(posedge clock) begin
      if (cmd.line_rd_col || cmd.err_calc) rdata_ff <= line_mem[rd_addr];
      if (wr_en) line_mem[wr_addr] <= wr_data;
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + CLW'(1);
      end
   end

   // error state
   logic signed [ERR_W-1:0] right_ff [3];
   logic signed [ERR_W-1:0] diag_ff  [3];
   logic signed [8:0]       e_ff     [3];
   logic signed [ERR_W-1:0] ee       [3];
   logic signed [ERR_W-1:0] e3       [3];
   logic signed [ERR_W-1:0] e5       [3];
   logic signed [ERR_W-1:0] e7       [3];
   logic signed [ERR_W-1:0] line_ch  [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         ee[ch]      = {{(ERR_W-9){e_ff[ch][8]}}, e_ff[ch]};
         e3[ch]      = (ee[ch] <<< 1) + ee[ch];
         e5[ch]      = (ee[ch] <<< 2) + ee[ch];
         e7[ch]      = (ee[ch] <<< 3) - ee[ch];
         line_ch[ch] = rdata_ff[ch*ERR_W +: ERR_W];
      end
   end

   // memory write mux
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = col_ff;
      wr_data = '0;
      if (cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
      end else if (cmd.wr_left) begin
         wr_en   = (col_ff != '0);
         wr_addr = col_m1;
         for (int ch = 0; ch < 3; ch++)
            wr_data[ch*ERR_W +: ERR_W] = line_ch[ch] + e3[ch];
      end else if (cmd.wr_cur) begin
         wr_en   = 1'b1;
         for (int ch = 0; ch < 3; ch++)
            wr_data[ch*ERR_W +: ERR_W] = diag_ff[ch] + e5[ch];
      end
   end

   // dithered color
   logic [7:0]         c_ff  [3];
   logic [7:0]         c_in  [3];
   logic signed [5:0]  b_off;
   logic signed [13:0] inc   [3];
   logic signed [14:0] s_fs  [3];
   logic signed [9:0]  s_by  [3];

   assign b_off = bayer_offset({row_ff[1:0], col_ff[1:0]});

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         inc[ch]  = {right_ff[ch][ERR_W-1], right_ff[ch]}
                  + ((row_ff != '0) ? {line_ch[ch][ERR_W-1], line_ch[ch]} : 14'sd0);
         s_fs[ch] = $signed({3'b000, pix_ff[ch], 4'b0000}) + {inc[ch][13], inc[ch]};
         s_by[ch] = $signed({2'b00, pix_ff[ch]}) + {{4{b_off[5]}}, b_off};
         if (mode_ff) begin
            if (s_fs[ch][14])
               c_in[ch] = 8'd0;
            else if (s_fs[ch][13:12] != 2'b00)
               c_in[ch] = 8'd255;
            else
               c_in[ch] = s_fs[ch][11:4];
         end else begin
            if (s_by[ch][9])
               c_in[ch] = 8'd0;
            else if (s_by[ch][8])
               c_in[ch] = 8'd255;
            else
               c_in[ch] = s_by[ch][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.adjust) begin
         for (int ch = 0; ch < 3; ch++) c_ff[ch] <= c_in[ch];
      end
   end

   // nearest-color search: stage 1 squares, stage 2 sum and compare
   logic [AW-1:0]      idx_ff, idx1_ff, best_idx_ff;
   logic               v1_ff;
   logic [31:0]        ent, ent1_ff, best_ent_ff;
   logic [16:0]        sq_ff [3];
   logic signed [9:0]  diff  [3];
   logic signed [19:0] sq    [3];
   logic [18:0]        sq_sum, best_d_ff;

   assign ent = pal_ff[idx_ff];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         diff[ch] = $signed({2'b00, c_ff[ch]}) - $signed({2'b00, ent[ch*8 +: 8]});
         sq[ch]   = diff[ch] * diff[ch];
      end
      sq_sum = 19'(sq_ff[0]) + 19'(sq_ff[1]) + 19'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.search_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.adjust) begin
         idx_ff    <= '0;
         best_d_ff <= '1;
      end else begin
         if (cmd.search_issue) begin
            idx_ff  <= idx_ff + AW'(1);
            idx1_ff <= idx_ff;
            ent1_ff <= ent;
            for (int ch = 0; ch < 3; ch++) sq_ff[ch] <= sq[ch][16:0];
         end
         if (v1_ff && (sq_sum < best_d_ff)) begin
            best_d_ff   <= sq_sum;
            best_idx_ff <= idx1_ff;
            best_ent_ff <= ent1_ff;
         end
      end
   end

   // error of the chosen color
   always_ff @(posedge clock) begin
      if (cmd.err_calc) begin
         for (int ch = 0; ch < 3; ch++)
            e_ff[ch] <= $signed({1'b0, c_ff[ch]}) - $signed({1'b0, best_ent_ff[ch*8 +: 8]});
      end
   end

   // right and diagonal error
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < 3; ch++) begin
            right_ff[ch] <= '0;
            diag_ff[ch]  <= '0;
         end
      end else if (cmd.wr_cur) begin
         for (int ch = 0; ch < 3; ch++) begin
            right_ff[ch] <= last_col ? '0 : e7[ch];
            diag_ff[ch]  <= last_col ? '0 : ee[ch];
         end
      end
   end

   // result register and frame position
   logic rsp_valid_ff;
   logic [31:0] rsp_ent_ff;
   logic [3:0]  rsp_idx_ff;
   logic        rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + 16'd1;
         end else begin
            col_ff <= col_ff + CLW'(1);
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ent_ff <= best_ent_ff;
         rsp_idx_ff <= 4'(best_idx_ff);
         rsp_end_ff <= last_col && last_row;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = rsp_ent_ff[7:0];
   assign rsp_out_green    = rsp_ent_ff[15:8];
   assign rsp_out_blue     = rsp_ent_ff[23:16];
   assign rsp_out_alpha    = rsp_ent_ff[31:24];
   assign rsp_chosen_index = rsp_idx_ff;
   assign rsp_frame_end    = rsp_end_ff;

   // status to controller
   assign status.clear_done  = (clr_ff == CLW'(MAX_WIDTH - 1));
   assign status.search_last = (SIZE_W'(idx_ff) + SIZE_W'(1)) >= n_eff;
   assign status.fs_mode     = mode_ff;
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;

   // search never reads past the active palette
   a_search_range: assert property (@(posedge clock) disable iff (reset)
      cmd.search_issue |-> (SIZE_W'(idx_ff) < n_eff))
      else $error("search index beyond palette size");

   // the left-column update follows the error calculation
   a_left_after_err: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_left |-> $past(cmd.err_calc))
      else $error("left update without fresh error");

endmodule

// ===== hdl/palette_dither_bayer_floyd_steinberg.sv =====
// ----------------------------------------------------------------------------
// palette_dither_bayer_floyd_steinberg
// Maps raster RGBA pixels to a loaded palette with Bayer 4x4 or
// Floyd-Steinberg dithering.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_ready    cmd, RGBA, entry_index
//   rsp      out        rsp_valid / rsp_ready    chosen RGBA, index, frame_end
//   csr      in         csr_wr_en                csr_index, csr_wdata
//
// A palette write is taken in the idle state. For a pixel the search over
// the active palette compares one palette entry per cycle, and
// Floyd-Steinberg mode adds the error update. After reset the error line
// is cleared before the first request is taken. A stalled result holds
// the next pixel in its last cycle until the output register frees.
// ----------------------------------------------------------------------------
module palette_dither_bayer_floyd_steinberg #(
   parameter int MAX_WIDTH     = pdither_pkg::DEF_MAX_WIDTH,
   parameter int PALETTE_DEPTH = pdither_pkg::DEF_PALETTE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [7:0]                        req_red,
   input  logic [7:0]                        req_green,
   input  logic [7:0]                        req_blue,
   input  logic [7:0]                        req_alpha,
   input  logic [3:0]                        req_entry_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_red,
   output logic [7:0]                        rsp_out_green,
   output logic [7:0]                        rsp_out_blue,
   output logic [7:0]                        rsp_out_alpha,
   output logic [3:0]                        rsp_chosen_index,
   output logic                              rsp_frame_end,
   input  logic                              csr_wr_en,
   input  logic [pdither_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdither_pkg::CSR_W-1:0]     csr_wdata
);
   import pdither_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   pdither_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pdither_dp #(
      .MAX_WIDTH     (MAX_WIDTH),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_alpha        (req_alpha),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_chosen_index (rsp_chosen_index),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

// ===== tb/sv/dither_checker.sv =====
// ----------------------------------------------------------------------------
// dither_checker
// Watches the request, result and register ports of the palette ditherer.
// It keeps its own copy of the palette, the registers and the error
// diffusion state, predicts each pixel result and compares it with the
// result that the block returns.
// ----------------------------------------------------------------------------
module dither_checker #(
   parameter int MAX_WIDTH     = pdither_pkg::DEF_MAX_WIDTH,
   parameter int PALETTE_DEPTH = pdither_pkg::DEF_PALETTE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [7:0]                        req_red,
   input  logic [7:0]                        req_green,
   input  logic [7:0]                        req_blue,
   input  logic [7:0]                        req_alpha,
   input  logic [3:0]                        req_entry_index,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [7:0]                        rsp_out_red,
   input  logic [7:0]                        rsp_out_green,
   input  logic [7:0]                        rsp_out_blue,
   input  logic [7:0]                        rsp_out_alpha,
   input  logic [3:0]                        rsp_chosen_index,
   input  logic                              rsp_frame_end,
   input  logic                              csr_wr_en,
   input  logic [pdither_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdither_pkg::CSR_W-1:0]     csr_wdata,
   output int                                fail_count,
   output int                                pending_count
);
   import pdither_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [3:0] index;
      logic       frame_end;
   } dithered_pixel_type;

   // Bayer 4x4 threshold values, indexed by row * 4 + column
   localparam int BAYER_K [16] = '{6, 14, 8, 16, 10, 2, 12, 4, 7, 15, 5, 13, 11, 3, 9, 1};

   logic               mode_fs;
   int                 width_reg, height_reg, psize_reg;
   logic [7:0]         palette [PALETTE_DEPTH][4];
   int                 err_below [MAX_WIDTH][3];
   int                 err_right [3];
   int                 err_diag [3];
   int                 col_pos, row_pos;
   dithered_pixel_type expected_pixels [$];

   // nearest palette entry by squared RGB distance, lower index wins ties
   function automatic int nearest_entry(input int c [3]);
      int n, best, best_d, d, diff;
      n = psize_reg == 0 ? 1 : (psize_reg > PALETTE_DEPTH ? PALETTE_DEPTH : psize_reg);
      best = 0;
      best_d = 32'h7fffffff;
      for (int i = 0; i < n; i++) begin
         d = 0;
         for (int ch = 0; ch < 3; ch++) begin
            diff = c[ch] - int'(palette[i][ch]);
            d += diff * diff;
         end
         if (d < best_d) begin
            best_d = d;
            best = i;
         end
      end
      return best;
   endfunction

   // dither one pixel and advance the frame position
   task automatic dither_pixel(input logic [7:0] r, g, b, output dithered_pixel_type res);
      int   w, h, col, sel, off, s, e;
      int   pix [3];
      int   c [3];
      logic last_col, last_row;
      pix = '{int'(r), int'(g), int'(b)};
      w = width_reg == 0 ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
      h = height_reg == 0 ? 1 : height_reg;
      col = col_pos < MAX_WIDTH ? col_pos : MAX_WIDTH - 1;
      last_col = col + 1 >= w;
      last_row = row_pos + 1 >= h;
      if (!mode_fs) begin
         off = ((BAYER_K[(col % 4) + (row_pos % 4) * 4] - 8) * 31) / 16;
         for (int ch = 0; ch < 3; ch++) begin
            s = pix[ch] + off;
            c[ch] = s < 0 ? 0 : (s > 255 ? 255 : s);
         end
         sel = nearest_entry(c);
      end else begin
         for (int ch = 0; ch < 3; ch++) begin
            s = pix[ch] * 16 + err_right[ch] + (row_pos > 0 ? err_below[col][ch] : 0);
            s = s < 0 ? 0 : s / 16;
            c[ch] = s > 255 ? 255 : s;
         end
         sel = nearest_entry(c);
         // spread the error in sixteenths: 7 right, 3 below-left, 5 below, 1 below-right
         for (int ch = 0; ch < 3; ch++) begin
            e = c[ch] - int'(palette[sel][ch]);
            if (col > 0) err_below[col-1][ch] += 3 * e;
            err_below[col][ch] = err_diag[ch] + 5 * e;
            err_diag[ch]  = last_col ? 0 : e;
            err_right[ch] = last_col ? 0 : 7 * e;
         end
      end
      res.red       = palette[sel][0];
      res.green     = palette[sel][1];
      res.blue      = palette[sel][2];
      res.alpha     = palette[sel][3];
      res.index     = sel[3:0];
      res.frame_end = last_col && last_row;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col + 1;
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      dithered_pixel_type want, got;
      if (reset) begin
         mode_fs = 1'b1;
         width_reg = 640;
         height_reg = 480;
         psize_reg = 16;
         for (int i = 0; i < PALETTE_DEPTH; i++) palette[i] = '{default: 8'd0};
         for (int i = 0; i < MAX_WIDTH; i++) err_below[i] = '{0, 0, 0};
         err_right = '{0, 0, 0};
         err_diag = '{0, 0, 0};
         col_pos = 0;
         row_pos = 0;
         expected_pixels.delete();
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               REG_DITHER_MODE:  mode_fs = csr_wdata[0];
               REG_IMAGE_WIDTH:  width_reg = int'(csr_wdata[10:0]);
               REG_IMAGE_HEIGHT: height_reg = int'(csr_wdata[15:0]);
               REG_PALETTE_SIZE: psize_reg = int'(csr_wdata[4:0]);
               default: ;
            endcase
         end
         // results against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha,
                    rsp_chosen_index, rsp_frame_end};
            if (expected_pixels.size() == 0) begin
               $error("result with no pixel request outstanding");
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("out_red", want.red, got.red);
               check_field("out_green", want.green, got.green);
               check_field("out_blue", want.blue, got.blue);
               check_field("out_alpha", want.alpha, got.alpha);
               check_field("chosen_index", want.index, got.index);
               check_field("frame_end", want.frame_end, got.frame_end);
            end
         end
         // accepted requests
         if (req_valid && req_ready) begin
            if (req_cmd) begin
               palette[req_entry_index] = '{req_red, req_green, req_blue, req_alpha};
            end else begin
               dither_pixel(req_red, req_green, req_blue, want);
               expected_pixels.push_back(want);
            end
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the palette ditherer through directed corner cases and random
// phases with both dither modes and many frame and palette sizes, with
// random gaps on the request side and random stalls on the result side.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import pdither_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 40;

   logic                 clock, reset;
   logic                 req_valid, req_ready, req_cmd;
   logic [7:0]           req_red, req_green, req_blue, req_alpha;
   logic [3:0]           req_entry_index;
   logic                 rsp_valid, rsp_ready;
   logic [7:0]           rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic [3:0]           rsp_chosen_index;
   logic                 rsp_frame_end;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   fail_count, pending_count;
   int                   cycle_count;
   int                   stall_left;
   logic                 calm;

   palette_dither_bayer_floyd_steinberg u_dut (.*);

   dither_checker u_checker (.*);

   // clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // result side stalls: mostly ready, short stalls, a few long ones
   always @(posedge clock) begin
      int pick;
      if (reset || calm) begin
         rsp_ready <= !reset;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         pick = $urandom_range(0, 99);
         rsp_ready <= pick < 80;
         if (pick >= 95) stall_left <= $urandom_range(10, 40);
         else if (pick >= 80) stall_left <= $urandom_range(0, 2);
      end
   end

   // one request, after a random gap; valid stays high when no gap follows
   task automatic send_request(input logic cmd, input logic [7:0] r, g, b, a,
                               input logic [3:0] slot);
      int pick, gap;
      pick = $urandom_range(0, 99);
      gap = (calm || pick < 70) ? 0 : (pick < 95 ? $urandom_range(1, 3) : $urandom_range(15, 60));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_alpha <= a;
      req_entry_index <= slot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold requests until every result is back and the block has settled
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_registers(input int mode, input int w, input int h, input int psize);
      csr_wr_en <= 1'b1;
      csr_index <= REG_DITHER_MODE;
      csr_wdata <= CSR_W'(mode);
      @(posedge clock);
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= CSR_W'(w);
      @(posedge clock);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_wdata <= CSR_W'(h);
      @(posedge clock);
      csr_index <= REG_PALETTE_SIZE;
      csr_wdata <= CSR_W'(psize);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random pixel, sometimes pushed to the channel extremes
   task automatic send_random_pixel;
      logic [7:0] c [3];
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(0, 9))
            0:       c[ch] = 8'd0;
            1:       c[ch] = 8'd255;
            2:       c[ch] = 8'($urandom_range(0, 12));
            3:       c[ch] = 8'($urandom_range(243, 255));
            default: c[ch] = 8'($urandom);
         endcase
      end
      send_request(1'b0, c[0], c[1], c[2], 8'($urandom), 4'($urandom));
   endtask

   // phase table: mode, width, height, palette size, pixel count
   int ph_mode [11] = '{1, 0, 1, 0, 1, 1, 1, 0, 1, 0, 1};
   int ph_w    [11] = '{4, 4, 1, 1, 1024, 0, 2047, 1024, 7, 13, 3};
   int ph_h    [11] = '{3, 4, 1, 65535, 65535, 0, 5, 1, 5, 6, 65535};
   int ph_p    [11] = '{16, 16, 1, 1, 16, 0, 31, 16, 8, 5, 16};
   int ph_n    [11] = '{60, 80, 40, 40, 300, 30, 200, 150, 150, 150, 150};

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      req_valid = 1'b0;
      req_cmd = 1'b0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      req_alpha = '0;
      req_entry_index = '0;
      rsp_ready = 1'b0;
      stall_left = 0;
      csr_wr_en = 1'b0;
      csr_index = REG_DITHER_MODE;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: full palette with black, white and a tie between slots 0 and 1
      set_registers(1, 4, 3, 16);
      send_request(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
      send_request(1'b1, 8'd0, 8'd0, 8'd0, 8'd255, 4'd1);
      send_request(1'b1, 8'd255, 8'd0, 8'd0, 8'd170, 4'd2);
      send_request(1'b1, 8'd0, 8'd255, 8'd0, 8'd85, 4'd3);
      send_request(1'b1, 8'd0, 8'd0, 8'd255, 8'd1, 4'd4);
      send_request(1'b1, 8'd128, 8'd128, 8'd128, 8'd128, 4'd5);
      for (int i = 6; i < 15; i++)
         send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 4'(i));
      send_request(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 4'd15);
      send_request(1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
      send_request(1'b0, 8'd255, 8'd255, 8'd255, 8'd255, 4'd15);
      send_request(1'b0, 8'd128, 8'd128, 8'd128, 8'd7, 4'd3);
      send_request(1'b0, 8'd255, 8'd0, 8'd0, 8'd0, 4'd0);
      send_request(1'b0, 8'd0, 8'd255, 8'd0, 8'd0, 4'd0);
      send_request(1'b0, 8'd0, 8'd0, 8'd255, 8'd0, 4'd0);
      send_request(1'b0, 8'd1, 8'd254, 8'd3, 8'd0, 4'd0);
      send_request(1'b0, 8'd200, 8'd60, 8'd10, 8'd0, 4'd0);
      send_request(1'b0, 8'd40, 8'd40, 8'd40, 8'd0, 4'd0);

      // phases of random pixels with the odd palette rewrite mixed in
      for (int ph = 0; ph < 14; ph++) begin
         int mode, w, h, psize, count;
         drain();
         calm = (ph % 4) == 2;
         if (ph < 11) begin
            mode = ph_mode[ph];
            w = ph_w[ph];
            h = ph_h[ph];
            psize = ph_p[ph];
            count = ph_n[ph];
         end else begin
            mode = $urandom_range(0, 1);
            w = $urandom_range(1, 20);
            h = $urandom_range(1, 8);
            psize = $urandom_range(1, 16);
            count = 100;
         end
         set_registers(mode, w, h, psize);
         for (int i = 0; i < 4; i++)
            send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         4'($urandom));
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            4'($urandom));
            send_random_pixel();
         end
      end

      drain();
      if (fail_count == 0 && pending_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
